>>> rtl/gdnw_pkg.sv
// Package for the Gregorian date neighbor and weekday unit.
// Holds the field types, the result record and the calendar table functions.
// Used by every module in rtl; depends on nothing.
package gdnw_pkg;

	typedef logic [13:0] year_t;
	typedef logic [3:0]  month_t;
	typedef logic [4:0]  day_t;
	typedef logic [8:0]  ordinal_t;
	typedef logic [2:0]  weekday_t;
	typedef logic [7:0]  century_t;

	localparam month_t MonthJan = 4'd1;
	localparam month_t MonthFeb = 4'd2;
	localparam month_t MonthDec = 4'd12;
	localparam day_t   DayFirst = 5'd1;
	localparam day_t   DayLast  = 5'd31;
	localparam ordinal_t DaysLeapYear = 9'd366;

	// Reciprocal of 100 scaled by 2^19, exact for every 14-bit year.
	localparam logic [12:0] Recip100 = 13'd5243;
	localparam int unsigned Recip100Shift = 19;

	typedef struct packed {
		year_t    next_year;
		month_t   next_month;
		day_t     next_day;
		year_t    prev_year;
		month_t   prev_month;
		day_t     prev_day;
		ordinal_t ordinal_day;
		weekday_t weekday;
		logic     date_invalid;
	} result_t;

	function automatic century_t div100(input year_t y);
		logic [26:0] prod;
		prod = 27'(y) * 27'(Recip100);
		return prod[26:Recip100Shift];
	endfunction

	function automatic logic leap_year(input year_t y);
		century_t q;
		year_t    r;
		q = div100(y);
		r = y - year_t'(14'(q) * 14'd100);
		return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
	endfunction

	function automatic day_t days_in(input month_t m, input logic leap);
		day_t len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic ordinal_t days_before(input month_t m);
		ordinal_t n;
		unique case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// Month term (13*m + 8) / 5 with January and February counted as 13 and 14.
	function automatic logic [5:0] month_term(input month_t m);
		logic [5:0] t;
		unique case (m)
			4'd1:    t = 6'd35;
			4'd2:    t = 6'd38;
			4'd3:    t = 6'd9;
			4'd4:    t = 6'd12;
			4'd5:    t = 6'd14;
			4'd6:    t = 6'd17;
			4'd7:    t = 6'd19;
			4'd8:    t = 6'd22;
			4'd9:    t = 6'd25;
			4'd10:   t = 6'd27;
			4'd11:   t = 6'd30;
			4'd12:   t = 6'd32;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

>>> rtl/gdnw_weekday.sv
// Weekday of a date by the Zeller-style sum, reduced modulo 7 by folding.
// Purely combinational; depends on gdnw_pkg for types and tables.
module gdnw_weekday (
	input  gdnw_pkg::year_t    year,
	input  gdnw_pkg::month_t   month,
	input  gdnw_pkg::day_t     day,
	output gdnw_pkg::weekday_t weekday
);
	import gdnw_pkg::*;

	logic        shift;
	logic        neg;
	year_t       yy;
	century_t    q100;
	logic [11:0] q4;
	logic [5:0]  q400;
	logic [14:0] sum;
	logic [5:0]  fold1;
	logic [3:0]  fold2;

	// January and February belong to the previous year; year zero shifts to minus one,
	// whose quotients truncate to zero.
	assign shift = (month == MonthJan) || (month == MonthFeb);
	assign neg   = shift && (year == '0);
	assign yy    = neg ? '0 : year - year_t'(shift);
	assign q100  = div100(yy);
	assign q4    = yy[13:2];
	assign q400  = q100[7:2];

	assign sum = 15'(year) + 15'(q4) + 15'(q400) + 15'(month_term(month)) + 15'(day)
		- 15'(q100) - 15'(shift);

	// Eight is one modulo 7, so three-bit digits may simply be added.
	assign fold1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9])
		+ 6'(sum[14:12]);
	assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
	assign weekday = (fold2 >= 4'd7) ? weekday_t'(fold2 - 4'd7) : weekday_t'(fold2);

endmodule

>>> rtl/gdnw_calendar.sv
// Date checks, following and preceding date, ordinal day and weekday of one date.
// Purely combinational; depends on gdnw_pkg and gdnw_weekday.
module gdnw_calendar (
	input  gdnw_pkg::year_t   year,
	input  gdnw_pkg::month_t  month,
	input  gdnw_pkg::day_t    day,
	output gdnw_pkg::result_t result
);
	import gdnw_pkg::*;

	logic     leap;
	day_t     dim;
	day_t     dim_prev;
	logic     invalid;
	weekday_t wd;
	result_t  res;

	assign leap     = leap_year(year);
	assign dim      = days_in(month, leap);
	assign dim_prev = days_in(month - 4'd1, leap);
	assign invalid  = (month == '0) || (month > MonthDec) || (day == '0) || (day > dim);

	gdnw_weekday u_weekday (
		.year    (year),
		.month   (month),
		.day     (day),
		.weekday (wd)
	);

	always_comb begin
		res = '0;
		if (invalid) begin
			res.date_invalid = 1'b1;
		end else begin
			res.next_year  = year;
			res.next_month = month;
			if (day < dim) begin
				res.next_day = day + 5'd1;
			end else begin
				res.next_day = DayFirst;
				if (month == MonthDec) begin
					res.next_month = MonthJan;
					res.next_year  = year + 14'd1;
				end else begin
					res.next_month = month + 4'd1;
				end
			end

			res.prev_year  = year;
			res.prev_month = month;
			if (day > DayFirst) begin
				res.prev_day = day - 5'd1;
			end else if (month == MonthJan) begin
				res.prev_month = MonthDec;
				res.prev_year  = year - 14'd1;
				res.prev_day   = DayLast;
			end else begin
				res.prev_month = month - 4'd1;
				res.prev_day   = dim_prev;
			end

			res.ordinal_day = days_before(month) + 9'(day)
				+ 9'(leap && (month > MonthFeb));
			res.weekday     = wd;
		end
	end

	assign result = res;

endmodule

>>> rtl/gregorian_date_neighbours_and_weekday_unit.sv
// Top level of the Gregorian date neighbor and weekday unit: input register,
// calendar logic and result register. Depends on gdnw_pkg and gdnw_calendar.
//
//   channel  handshake            payload
//   in       in_valid, in_stall   year, month, day
//   out      out_valid, out_stall next_year .. weekday, date_invalid
//
// One date is taken in every cycle while in_stall is low; its result passes the input
// and result registers. The rate is set by the single pass through the calendar logic.
// Reset clears both valid bits; no result is pending after reset.
// A stalled output holds its result, and the input stalls only when both stages are full.
module gregorian_date_neighbours_and_weekday_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gdnw_pkg::year_t    year,
	input  gdnw_pkg::month_t   month,
	input  gdnw_pkg::day_t     day,
	output logic               out_valid,
	input  logic               out_stall,
	output gdnw_pkg::year_t    next_year,
	output gdnw_pkg::month_t   next_month,
	output gdnw_pkg::day_t     next_day,
	output gdnw_pkg::year_t    prev_year,
	output gdnw_pkg::month_t   prev_month,
	output gdnw_pkg::day_t     prev_day,
	output gdnw_pkg::ordinal_t ordinal_day,
	output gdnw_pkg::weekday_t weekday,
	output logic               date_invalid
);
	import gdnw_pkg::*;

	logic    valid_s1;
	year_t   year_s1;
	month_t  month_s1;
	day_t    day_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_c;
	logic    adv_s1;
	logic    adv_s2;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	gdnw_calendar u_calendar (
		.year   (year_s1),
		.month  (month_s1),
		.day    (day_s1),
		.result (res_c)
	);

	assign out_valid    = valid_s2;
	assign next_year    = res_s2.next_year;
	assign next_month   = res_s2.next_month;
	assign next_day     = res_s2.next_day;
	assign prev_year    = res_s2.prev_year;
	assign prev_month   = res_s2.prev_month;
	assign prev_day     = res_s2.prev_day;
	assign ordinal_day  = res_s2.ordinal_day;
	assign weekday      = res_s2.weekday;
	assign date_invalid = res_s2.date_invalid;

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted transfer did not reach the input register");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> out_valid)
		else $error("input register content did not reach the result register");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && valid_s1 |-> in_stall)
		else $error("input not stalled while both stages are full");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_invalid |-> next_year == '0 && next_month == '0
			&& prev_day == '0 && ordinal_day == '0 && weekday == '0)
		else $error("invalid date result carries nonzero fields");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !date_invalid |-> ordinal_day != '0 && ordinal_day <= DaysLeapYear
			&& weekday <= 3'd6 && next_day != '0 && prev_day != '0)
		else $error("valid date result out of range");

endmodule
